FILE: design/bth_pkg.sv
// Package for the boundary tag heap allocator.
// Holds opcodes, status codes and tag field constants; no dependencies.
`default_nettype none

package bth_pkg;

   // Operation codes of a request
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes of a response
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // Tag layout: size in bits 15:3, allocated flag in bit 0
   localparam logic [15:0] TAG_SIZE_MASK = 16'hFFF8;
   localparam logic [15:0] TAG_USED      = 16'h0001;
   localparam logic [16:0] TAG_META      = 17'd4;
   localparam logic [16:0] TAG_HALF      = 17'd2;
   localparam logic [16:0] ALIGN_ROUND   = 17'd7;
   localparam logic [16:0] ALIGN_MASK    = 17'h1FFF8;

endpackage

`default_nettype wire

FILE: design/bth_channels.sv
// Request and response channel interfaces of the heap allocator.
// Depends on bth_pkg for nothing but a common import point.
`default_nettype none

interface bth_req_if
   import bth_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] request_bytes;
   logic [15:0] block_address;

   modport source (output valid, opcode, request_bytes, block_address, input ready);
   modport sink   (input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface bth_rsp_if
   import bth_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] payload_address;
   logic [15:0] free_bytes;

   modport source (output valid, status, payload_address, free_bytes, input ready);
   modport sink   (input valid, status, payload_address, free_bytes, output ready);
endinterface

`default_nettype wire

FILE: design/bth_tag_ram.sv
// Single-port tag memory with registered read data (read-first).
// Depends on nothing; sized by the top level.
`default_nettype none

module bth_tag_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic          we,
   input  wire logic [AW-1:0] addr,
   input  wire logic [15:0]   wdata,
   output logic      [15:0]   rdata
);

   logic [15:0] tag_mem_ff [DEPTH];
   logic [15:0] rdata_ff;

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            tag_mem_ff[addr] <= wdata;
         end
         rdata_ff <= tag_mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/boundary_tag_heap_allocator.sv
// Top level of the boundary tag first-fit heap allocator: walk sequencer,
// free-total register and response register. Depends on bth_pkg,
// bth_channels (bth_req_if, bth_rsp_if) and bth_tag_ram.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | opcode, request_bytes, block_address      | valid/ready
//   rsp     | out | status, payload_address, free_bytes       | valid/ready
//
// One request at a time. The tag memory has one port, so each block visited
// by a walk costs a read and a check, and each tag write an access of its own.
// An allocate walks to the first fit and writes its header and footer, then
// those of the remainder when the block is split; a free walks to the target,
// rewrites its tags and then merges with the block before and the block after.
// After reset a clearing pass writes every tag entry and rebuilds the single
// free block; req.ready stays low until it ends.
// A waiting response does not hold off the next request; only its own
// completion waits for the response register to drain.
`default_nettype none

module boundary_tag_heap_allocator
   import bth_pkg::*;
#(
   parameter int ARENA_BYTES = 4096
) (
   input wire logic clock,
   input wire logic reset,
   bth_req_if.sink  req,
   bth_rsp_if.source rsp
);

   localparam int ALIGN_BYTES = 8;
   localparam int ARENA_END   = ARENA_BYTES - (ARENA_BYTES % ALIGN_BYTES);
   localparam int TAG_DEPTH   = ARENA_BYTES / 2;
   localparam int AW          = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

   localparam logic [16:0]   END17      = 17'(ARENA_END);
   localparam logic [15:0]   DEPTH16    = 16'(TAG_DEPTH);
   localparam logic [AW-1:0] CLR_LAST   = AW'(TAG_DEPTH - 1);
   localparam logic [AW-1:0] FOOT_IDX   = AW'(ARENA_END / 2 - 1);
   localparam logic [15:0]   INIT_TAG   = 16'(ARENA_END) & TAG_SIZE_MASK;
   localparam logic [15:0]   INIT_FREE  = 16'(ARENA_END - 4);

   // Sequencer states
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_A_RD    = 4'd2;
   localparam logic [3:0] S_A_CHK   = 4'd3;
   localparam logic [3:0] S_A_SPLIT = 4'd4;
   localparam logic [3:0] S_F_RD    = 4'd5;
   localparam logic [3:0] S_F_CHK   = 4'd6;
   localparam logic [3:0] S_F_TST   = 4'd7;
   localparam logic [3:0] S_WP_HDR  = 4'd8;
   localparam logic [3:0] S_WP_FTR  = 4'd9;
   localparam logic [3:0] S_MP_RD   = 4'd10;
   localparam logic [3:0] S_MP_CK   = 4'd11;
   localparam logic [3:0] S_MN_RD   = 4'd12;
   localparam logic [3:0] S_MN_CK   = 4'd13;
   localparam logic [3:0] S_FINISH  = 4'd14;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [16:0]   p_ff, p_in;
   logic [15:0]   size_ff, size_in;
   logic [16:0]   need_ff, need_in;
   logic [15:0]   target_ff, target_in;
   logic [16:0]   wr_base_ff, wr_base_in;
   logic [16:0]   wr_size_ff, wr_size_in;
   logic          wr_used_ff, wr_used_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   payload_ff, payload_in;
   logic [15:0]   free_ff, free_in;
   logic          oob_ff, oob_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_payload_ff, rsp_payload_in;
   logic [15:0]   rsp_free_ff, rsp_free_in;

   // Tag memory access
   logic          acc_go;
   logic          acc_we;
   logic [16:0]   acc_off;
   logic [15:0]   acc_wdata;
   logic          acc_in_range;
   logic          ram_en;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_rdata;

   logic [15:0]   tag_rd;
   logic [15:0]   rd_size;
   logic          rd_used;
   logic [15:0]   wr_tag;
   logic [16:0]   need_calc;
   logic [16:0]   next_off;
   logic [16:0]   grow_sum;
   logic          accept;

   bth_tag_ram #(
      .DEPTH (TAG_DEPTH),
      .AW    (AW)
   ) u_tag_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (acc_we),
      .addr  (ram_addr),
      .wdata (acc_wdata),
      .rdata (ram_rdata)
   );

   // Drop accesses beyond the memory; such a read returns zero
   assign acc_in_range = (acc_off[16:1] < DEPTH16);
   assign ram_en       = acc_go && acc_in_range;
   assign ram_addr     = acc_off[AW:1];

   assign tag_rd    = oob_ff ? 16'd0 : ram_rdata;
   assign rd_size   = tag_rd & TAG_SIZE_MASK;
   assign rd_used   = tag_rd[0];
   assign wr_tag    = (wr_size_ff[15:0] & TAG_SIZE_MASK) | (wr_used_ff ? TAG_USED : 16'd0);
   assign need_calc = ({1'b0, req.request_bytes} + TAG_META + ALIGN_ROUND) & ALIGN_MASK;
   assign next_off  = p_ff + {1'b0, size_ff};
   assign accept    = req.valid && req.ready;

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.payload_address = rsp_payload_ff;
   assign rsp.free_bytes      = rsp_free_ff;

   // Sequence walks, splits and merges
   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      clr_in         = clr_ff;
      p_in           = p_ff;
      size_in        = size_ff;
      need_in        = need_ff;
      target_in      = target_ff;
      wr_base_in     = wr_base_ff;
      wr_size_in     = wr_size_ff;
      wr_used_in     = wr_used_ff;
      status_in      = status_ff;
      payload_in     = payload_ff;
      free_in        = free_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_free_in    = rsp_free_ff;
      acc_go         = 1'b0;
      acc_we         = 1'b0;
      acc_off        = p_ff;
      acc_wdata      = wr_tag;
      grow_sum       = 17'd0;

      // Release the response once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            acc_go    = 1'b1;
            acc_we    = 1'b1;
            acc_off   = {16'(clr_ff), 1'b0};
            acc_wdata = (clr_ff == '0 || clr_ff == FOOT_IDX) ? INIT_TAG : 16'd0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               payload_in = 16'd0;
               p_in       = 17'd0;
               need_in    = need_calc;
               target_in  = req.block_address - 16'd2;
               status_in  = ST_REJECT;
               if (req.opcode == OP_ALLOC) begin
                  if (req.request_bytes == 16'd0) begin
                     state_in = S_FINISH;
                  end else begin
                     status_in = ST_NOFIT;
                     state_in  = S_A_RD;
                  end
               end else if (req.block_address >= 16'd2 &&
                            {1'b0, req.block_address} < END17) begin
                  state_in = S_F_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_A_RD: begin
            if (p_ff < END17) begin
               acc_go   = 1'b1;
               state_in = S_A_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_A_CHK: begin
            if (rd_size == 16'd0) begin
               state_in = S_FINISH;
            end else if (!rd_used && {1'b0, rd_size} >= need_ff) begin
               size_in    = rd_size;
               wr_base_in = p_ff;
               wr_size_in = need_ff;
               wr_used_in = 1'b1;
               ret_in     = S_A_SPLIT;
               status_in  = ST_DONE;
               payload_in = p_ff[15:0] + 16'd2;
               if ({1'b0, rd_size} > need_ff) begin
                  free_in = free_ff - need_ff[15:0];
               end else begin
                  free_in = free_ff - (rd_size - 16'd4);
               end
               state_in = S_WP_HDR;
            end else begin
               p_in     = p_ff + {1'b0, rd_size};
               state_in = S_A_RD;
            end
         end
         S_A_SPLIT: begin
            if ({1'b0, size_ff} > need_ff) begin
               wr_base_in = p_ff + need_ff;
               wr_size_in = {1'b0, size_ff} - need_ff;
               wr_used_in = 1'b0;
               ret_in     = S_FINISH;
               state_in   = S_WP_HDR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_WP_HDR: begin
            acc_go   = 1'b1;
            acc_we   = 1'b1;
            acc_off  = wr_base_ff;
            state_in = S_WP_FTR;
         end
         S_WP_FTR: begin
            acc_go   = 1'b1;
            acc_we   = 1'b1;
            acc_off  = wr_base_ff + wr_size_ff - TAG_HALF;
            state_in = ret_ff;
         end
         S_F_RD: begin
            if (p_ff < {1'b0, target_ff}) begin
               acc_go   = 1'b1;
               state_in = S_F_CHK;
            end else if (p_ff == {1'b0, target_ff}) begin
               acc_go   = 1'b1;
               state_in = S_F_TST;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_F_CHK: begin
            if (rd_size == 16'd0) begin
               state_in = S_FINISH;
            end else begin
               p_in     = p_ff + {1'b0, rd_size};
               state_in = S_F_RD;
            end
         end
         S_F_TST: begin
            if (rd_used) begin
               size_in    = rd_size;
               free_in    = free_ff + (rd_size - 16'd4);
               wr_base_in = p_ff;
               wr_size_in = {1'b0, rd_size};
               wr_used_in = 1'b0;
               ret_in     = S_MP_RD;
               status_in  = ST_DONE;
               state_in   = S_WP_HDR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MP_RD: begin
            if (p_ff > TAG_HALF) begin
               acc_go   = 1'b1;
               acc_off  = p_ff - TAG_HALF;
               state_in = S_MP_CK;
            end else begin
               state_in = S_MN_RD;
            end
         end
         S_MP_CK: begin
            if (!rd_used) begin
               if (rd_size == 16'd0 || {1'b0, rd_size} > p_ff) begin
                  state_in = S_FINISH;
               end else begin
                  grow_sum   = {1'b0, size_ff} + {1'b0, rd_size};
                  p_in       = p_ff - {1'b0, rd_size};
                  size_in    = grow_sum[15:0] & TAG_SIZE_MASK;
                  wr_base_in = p_ff - {1'b0, rd_size};
                  wr_size_in = grow_sum;
                  wr_used_in = 1'b0;
                  free_in    = free_ff + 16'd4;
                  ret_in     = S_MP_RD;
                  state_in   = S_WP_HDR;
               end
            end else begin
               state_in = S_MN_RD;
            end
         end
         S_MN_RD: begin
            if (next_off < END17) begin
               acc_go   = 1'b1;
               acc_off  = next_off;
               state_in = S_MN_CK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MN_CK: begin
            if (!rd_used && rd_size != 16'd0) begin
               grow_sum   = {1'b0, size_ff} + {1'b0, rd_size};
               size_in    = grow_sum[15:0] & TAG_SIZE_MASK;
               wr_base_in = p_ff;
               wr_size_in = grow_sum;
               wr_used_in = 1'b0;
               free_in    = free_ff + 16'd4;
               ret_in     = S_MP_RD;
               state_in   = S_WP_HDR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_payload_in = payload_ff;
               rsp_free_in    = free_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign oob_in = acc_go && !acc_in_range;

   // Hold control state; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= INIT_FREE;
         rsp_valid_ff <= 1'b0;
         oob_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         oob_ff       <= oob_in;
      end
   end

   // Advance walk and response payload
   always_ff @(posedge clock) begin
      ret_ff         <= ret_in;
      p_ff           <= p_in;
      size_ff        <= size_in;
      need_ff        <= need_in;
      target_ff      <= target_in;
      wr_base_ff     <= wr_base_in;
      wr_size_ff     <= wr_size_in;
      wr_used_ff     <= wr_used_in;
      status_ff      <= status_in;
      payload_ff     <= payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_free_ff    <= rsp_free_in;
   end

endmodule

`default_nettype wire

FILE: sim/tb_boundary_tag_heap_allocator.sv
`timescale 1ns / 1ps
// Testbench for boundary_tag_heap_allocator: directed and random allocate/free requests,
// each response checked against a boundary-tag heap predictor kept in the bench.
// Depends on bth_pkg, bth_channels (bth_req_if, bth_rsp_if) and the allocator RTL.

module tb_boundary_tag_heap_allocator;
   import bth_pkg::*;

   localparam int ARENA_BYTES = 4096;
   localparam int ARENA_END   = ARENA_BYTES & ~7;
   localparam int TAG_DEPTH   = ARENA_BYTES / 2;
   localparam int RANDOM_REQS = 1150;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic        opcode;
      logic [15:0] request_bytes;
      logic [15:0] block_address;
   } heap_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_address;
      logic [15:0] free_bytes;
   } heap_rsp_type;

   logic clock;
   logic reset;

   bth_req_if req_bus ();
   bth_rsp_if rsp_bus ();

   boundary_tag_heap_allocator #(
      .ARENA_BYTES(ARENA_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   // Heap image: one tag per even byte offset, plus the running free payload total
   logic [15:0] heap_tags [TAG_DEPTH];
   int unsigned heap_free_total;

   heap_req_type req_backlog [$];
   heap_rsp_type rsp_expected [$];
   logic [15:0]  live_blocks [$];

   int          errors;
   int unsigned cycle_count;
   int          burst_left;
   int          gap_left;
   logic [7:0]  ready_pat;
   int          pat_age;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] tag_at(int unsigned off);
      if ((off >> 1) >= TAG_DEPTH) return 16'h0;
      return heap_tags[off >> 1];
   endfunction

   function automatic void tag_put(int unsigned off, logic [15:0] value);
      if ((off >> 1) < TAG_DEPTH) heap_tags[off >> 1] = value;
   endfunction

   // Write header and footer of one block
   function automatic void mark_block(int unsigned off, int unsigned blk_size, bit used);
      logic [15:0] tag;
      tag = (blk_size[15:0] & TAG_SIZE_MASK) | (used ? TAG_USED : 16'h0);
      tag_put(off, tag);
      tag_put(off + blk_size - TAG_HALF, tag);
   endfunction

   function automatic void heap_reset();
      for (int i = 0; i < TAG_DEPTH; i++) heap_tags[i] = 16'h0;
      mark_block(0, ARENA_END, 1'b0);
      heap_free_total = ARENA_END - TAG_META;
      live_blocks.delete();
   endfunction

   // Fold free neighbors into the block at start until none is left;
   // each fold frees one set of tags
   function automatic void coalesce_from(int unsigned start);
      int unsigned blk_size;
      int unsigned nxt;
      int unsigned nbr;
      bit          merging;
      bit          prev_free;
      bit          next_free;
      merging = 1'b1;
      while (merging) begin
         blk_size  = tag_at(start) & TAG_SIZE_MASK;
         nxt       = start + blk_size;
         prev_free = (start > TAG_HALF) && ((tag_at(start - TAG_HALF) & TAG_USED) == 0);
         next_free = (nxt < ARENA_END) && ((tag_at(nxt) & TAG_USED) == 0);
         merging   = 1'b0;
         if (prev_free) begin
            nbr = tag_at(start - TAG_HALF) & TAG_SIZE_MASK;
            if (nbr != 0 && nbr <= start) begin
               start -= nbr;
               mark_block(start, blk_size + nbr, 1'b0);
               merging = 1'b1;
            end
         end else if (next_free) begin
            nbr = tag_at(nxt) & TAG_SIZE_MASK;
            if (nbr != 0) begin
               mark_block(start, blk_size + nbr, 1'b0);
               merging = 1'b1;
            end
         end
         if (merging) heap_free_total += TAG_META;
      end
   endfunction

   // Apply one request to the heap image and return the response it should give
   function automatic heap_rsp_type predict_heap_op(heap_req_type r);
      heap_rsp_type res;
      int unsigned  need;
      int unsigned  p;
      int unsigned  sz;
      int unsigned  target;
      logic [15:0]  tag;
      bit           searching;
      res.status          = ST_REJECT;
      res.payload_address = 16'h0;
      if (r.opcode == OP_ALLOC) begin
         if (r.request_bytes != 16'h0) begin
            need = r.request_bytes;
            need = (need + TAG_META + ALIGN_ROUND) & ~32'd7;
            res.status = ST_NOFIT;
            p = 0;
            searching = 1'b1;
            // first fit: take the first free block that holds the rounded size
            while (searching && p < ARENA_END) begin
               tag = tag_at(p);
               sz  = tag & TAG_SIZE_MASK;
               if (sz == 0) begin
                  searching = 1'b0;
               end else if ((tag & TAG_USED) == 0 && sz >= need) begin
                  mark_block(p, need, 1'b1);
                  if (sz > need) begin
                     mark_block(p + need, sz - need, 1'b0);
                     heap_free_total -= need;
                  end else begin
                     heap_free_total -= sz - TAG_META;
                  end
                  res.status          = ST_DONE;
                  res.payload_address = 16'(p + TAG_HALF);
                  searching = 1'b0;
               end else begin
                  p += sz;
               end
            end
         end
      end else if (r.block_address >= TAG_HALF && r.block_address < ARENA_END) begin
         target = r.block_address - TAG_HALF;
         p = 0;
         searching = 1'b1;
         // walk from the arena start; the address must land on a block header
         while (searching && p < target) begin
            sz = tag_at(p) & TAG_SIZE_MASK;
            if (sz == 0) searching = 1'b0;
            else p += sz;
         end
         if (p == target && (tag_at(p) & TAG_USED) != 0) begin
            sz = tag_at(p) & TAG_SIZE_MASK;
            mark_block(p, sz, 1'b0);
            heap_free_total += sz - TAG_META;
            coalesce_from(p);
            res.status = ST_DONE;
         end
      end
      res.free_bytes = heap_free_total[15:0];
      return res;
   endfunction

   function automatic void forget_block(logic [15:0] addr);
      for (int i = 0; i < live_blocks.size(); i++) begin
         if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
         end
      end
   endfunction

   function automatic void add_req(logic op, logic [15:0] bytes, logic [15:0] addr);
      heap_req_type r;
      r.opcode        = op;
      r.request_bytes = bytes;
      r.block_address = addr;
      req_backlog.push_back(r);
   endfunction

   // Build one random request: mostly allocates and frees of live blocks,
   // the rest odd sizes, zero sizes and frees of stray addresses
   function automatic heap_req_type make_heap_req(bit fill_phase);
      heap_req_type r;
      int unsigned  roll;
      int unsigned  pick;
      r.opcode        = OP_ALLOC;
      r.request_bytes = 16'($urandom_range(0, 65535));
      r.block_address = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         // keep the full-range size
      end else if (roll < 5) begin
         r.request_bytes = 16'h0;
      end else if (roll < 9) begin
         r.opcode = OP_FREE;
      end else if (roll < 12) begin
         r.opcode        = OP_FREE;
         r.block_address = 16'($urandom_range(0, ARENA_END / 2 - 1) * 2);
      end else if (roll < 14 && live_blocks.size() != 0) begin
         pick            = $urandom_range(0, live_blocks.size() - 1);
         r.opcode        = OP_FREE;
         r.block_address = live_blocks[pick] + 16'($urandom_range(1, 9));
      end else if ((fill_phase ? roll < 70 : roll < 35) || live_blocks.size() == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      r.request_bytes = 16'($urandom_range(1, 64));
         else if (pick < 80) r.request_bytes = 16'($urandom_range(65, 512));
         else if (pick < 95) r.request_bytes = 16'($urandom_range(513, 1500));
         else                r.request_bytes = 16'($urandom_range(1501, ARENA_END - 4));
      end else begin
         pick            = $urandom_range(0, live_blocks.size() - 1);
         r.opcode        = OP_FREE;
         r.block_address = live_blocks[pick];
      end
      return r;
   endfunction

   // Drive requests from the backlog in bursts with idle gaps; predict on acceptance
   always @(posedge clock) begin
      heap_req_type seen_req;
      heap_req_type next_req;
      heap_rsp_type outcome;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen_req.opcode        = req_bus.opcode;
            seen_req.request_bytes = req_bus.request_bytes;
            seen_req.block_address = req_bus.block_address;
            outcome = predict_heap_op(seen_req);
            rsp_expected.push_back(outcome);
            if (outcome.status == ST_DONE) begin
               if (seen_req.opcode == OP_ALLOC) live_blocks.push_back(outcome.payload_address);
               else forget_block(seen_req.block_address);
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               next_req = req_backlog.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.opcode        <= next_req.opcode;
               req_bus.request_bytes <= next_req.request_bytes;
               req_bus.block_address <= next_req.block_address;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Check each response against the oldest prediction; stall on a rotating pattern
   always @(posedge clock) begin
      heap_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         ready_pat = 8'hFF;
         pat_age   = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_expected.size() == 0) begin
               errors++;
               $display("%0t: response with none expected: status %0d addr %0d free %0d",
                        $time, rsp_bus.status, rsp_bus.payload_address, rsp_bus.free_bytes);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_bus.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_bus.status);
               end
               if (rsp_bus.payload_address !== want.payload_address) begin
                  errors++;
                  $display("%0t: payload_address expected %0d got %0d",
                           $time, want.payload_address, rsp_bus.payload_address);
               end
               if (rsp_bus.free_bytes !== want.free_bytes) begin
                  errors++;
                  $display("%0t: free_bytes expected %0d got %0d",
                           $time, want.free_bytes, rsp_bus.free_bytes);
               end
            end
         end
         // rotate the stall pattern, and reload it when pat_age reaches 31
         if (pat_age == 31) begin
            pat_age   = 0;
            ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
         end else begin
            pat_age++;
            ready_pat = {ready_pat[0], ready_pat[7:1]};
         end
         rsp_bus.ready <= ready_pat[0];
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** boundary_tag_heap_allocator: FAILED **");
         $finish;
      end
   end

   initial begin
      errors      = 0;
      cycle_count = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_ALLOC;
      req_bus.request_bytes = 16'h0;
      req_bus.block_address = 16'h0;
      rsp_bus.ready         = 1'b0;
      heap_reset();

      // zero size, oversized, too large after rounding, exact fit of the whole arena, full arena
      add_req(OP_ALLOC, 16'd0, 16'hFFFF);
      add_req(OP_ALLOC, 16'hFFFF, 16'h0);
      add_req(OP_ALLOC, 16'(ARENA_END - 3), 16'h0);
      add_req(OP_ALLOC, 16'(ARENA_END - 4), 16'h0);
      add_req(OP_ALLOC, 16'd1, 16'h0);
      // free, double free, addresses outside the arena
      add_req(OP_FREE, 16'h0, 16'd2);
      add_req(OP_FREE, 16'hFFFF, 16'd2);
      add_req(OP_FREE, 16'h0, 16'd0);
      add_req(OP_FREE, 16'h0, 16'(ARENA_END));
      add_req(OP_FREE, 16'h0, 16'hFFFF);
      add_req(OP_FREE, 16'h0, 16'd1);
      // four small blocks, then a free that is not on a block header
      add_req(OP_ALLOC, 16'd1, 16'h0);
      add_req(OP_ALLOC, 16'd12, 16'h0);
      add_req(OP_ALLOC, 16'd20, 16'h0);
      add_req(OP_ALLOC, 16'd4, 16'h0);
      add_req(OP_FREE, 16'h0, 16'd3);
      // no merge, merge with next, merge with next again, merge on both sides
      add_req(OP_FREE, 16'h0, 16'd10);
      add_req(OP_FREE, 16'h0, 16'd2);
      add_req(OP_FREE, 16'h0, 16'd50);
      add_req(OP_FREE, 16'h0, 16'd26);
      // split leaving the smallest block, then its exact fit, then free both
      add_req(OP_ALLOC, 16'(ARENA_END - 12), 16'h0);
      add_req(OP_ALLOC, 16'd4, 16'h0);
      add_req(OP_FREE, 16'h0, 16'(ARENA_END - 6));
      add_req(OP_FREE, 16'h0, 16'd2);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // alternate fill-heavy and drain-heavy stretches of random requests
      for (int n = 0; n < RANDOM_REQS; n++) begin
         @(negedge clock);
         while (req_backlog.size() >= 2) @(negedge clock);
         req_backlog.push_back(make_heap_req(((n / 100) % 2) == 0));
      end

      // drain
      while (req_backlog.size() != 0 || req_bus.valid) @(negedge clock);
      while (rsp_expected.size() != 0) @(negedge clock);
      repeat (ARENA_BYTES) @(negedge clock);

      if (errors == 0) begin
         $display("** boundary_tag_heap_allocator: PASSED **");
      end else begin
         $display("** boundary_tag_heap_allocator: FAILED **");
      end
      $finish;
   end

endmodule
